// ===== src/arp_address_resolver_core_macros.svh =====
// ----------------------------------------------------------------------------
// ARP resolver assertion macros
// Clocked concurrent assertion wrappers, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ARP_ADDRESS_RESOLVER_CORE_MACROS_SVH
`define ARP_ADDRESS_RESOLVER_CORE_MACROS_SVH

// assertion masked while reset is asserted
`define ARP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("arp resolver assertion failed");

// assertion checked in every cycle, reset included
`define ARP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("arp resolver assertion failed");

`endif

// ===== src/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP resolver package
// Shared types and protocol constants of the ARP resolver.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int POS_W   = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RX    = 1'b1;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IP = 2'd2;

  localparam logic [7:0]  BCAST_BYTE    = 8'hff;
  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] HTYPE_ETH     = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  HLEN_ETH      = 8'd6;
  localparam logic [7:0]  PLEN_IPV4     = 8'd4;
  localparam logic [15:0] OP_REQUEST    = 16'h0001;
  localparam logic [15:0] OP_REPLY      = 16'h0002;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [MAC_W-1:0] own_mac;
    logic [IP_W-1:0]  own_ip;
    logic [IP_W-1:0]  target_ip;
  } cfg_t;

  typedef struct packed {
    logic             report;
    logic [MAC_W-1:0] mac;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEND
  } back_state_t;

endpackage

// ===== src/arp_if.sv =====
// ----------------------------------------------------------------------------
// ARP resolver channel interfaces
// Valid/ready channels for input requests and result items.
// ----------------------------------------------------------------------------
interface arp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output command, output rx_byte, output rx_last,
                  input ready);
  modport sink   (input valid, input command, input rx_byte, input rx_last,
                  output ready);
endinterface

interface arp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        tx_last;
  logic [47:0] resolved_mac;

  modport source (output valid, output kind, output tx_byte, output tx_last,
                  output resolved_mac, input ready);
  modport sink   (input valid, input kind, input tx_byte, input tx_last,
                  input resolved_mac, output ready);
endinterface

// ===== src/arp_queue.sv =====
// ----------------------------------------------------------------------------
// ARP job queue
// Short FIFO of jobs between the parsing front end and the transmit back end.
// ----------------------------------------------------------------------------
module arp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  arp_pkg::q_entry_t   push_entry,
  input  logic                pop,
  output arp_pkg::q_entry_t   head,
  output arp_pkg::q_status_t  status
);

  arp_pkg::q_entry_t                 entries_r [arp_pkg::QUEUE_DEPTH];
  logic [arp_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [arp_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [arp_pkg::QPTR_W:0]          count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = entries_r[rd_ptr_r];
  assign status.full  = (count_r == (arp_pkg::QPTR_W+1)'(arp_pkg::QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

// ===== src/arp_front.sv =====
// ----------------------------------------------------------------------------
// ARP front end
// Accepts requests, parses received frames by position and queues jobs.
// ----------------------------------------------------------------------------
module arp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  arp_in_if.sink                       in_ch,
  input  logic [arp_pkg::IP_W-1:0]     target_ip,
  input  arp_pkg::q_status_t           q_status,
  output logic                         push,
  output arp_pkg::q_entry_t            push_entry
);

  logic                         armed_r, armed_nxt;
  logic [arp_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                         eth_ok_r, eth_ok_nxt;
  logic                         op_ok_r, op_ok_nxt;
  logic                         ip_ok_r, ip_ok_nxt;
  logic [arp_pkg::MAC_W-1:0]    mac_r, mac_nxt;
  logic                         accept;
  logic [7:0]                   tgt_byte;
  logic [7:0]                   b;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  always_comb begin
    case (pos_r[1:0])
      2'd0:    tgt_byte = target_ip[31:24];
      2'd1:    tgt_byte = target_ip[23:16];
      2'd2:    tgt_byte = target_ip[15:8];
      2'd3:    tgt_byte = target_ip[7:0];
      default: tgt_byte = target_ip[7:0];
    endcase
  end

  always_comb begin
    armed_nxt         = armed_r;
    pos_nxt           = pos_r;
    eth_ok_nxt        = eth_ok_r;
    op_ok_nxt         = op_ok_r;
    ip_ok_nxt         = ip_ok_r;
    mac_nxt           = mac_r;
    push              = 1'b0;
    push_entry.report = 1'b0;
    if (accept) begin
      if (in_ch.command == arp_pkg::CMD_START) begin
        push      = 1'b1;
        armed_nxt = 1'b1;
      end else begin
        if (pos_r == 6'd12 && b != arp_pkg::ETHERTYPE_ARP[15:8]) eth_ok_nxt = 1'b0;
        if (pos_r == 6'd13 && b != arp_pkg::ETHERTYPE_ARP[7:0])  eth_ok_nxt = 1'b0;
        if (pos_r == 6'd20 && b != arp_pkg::OP_REPLY[15:8])      op_ok_nxt  = 1'b0;
        if (pos_r == 6'd21 && b != arp_pkg::OP_REPLY[7:0])       op_ok_nxt  = 1'b0;
        if (pos_r >= 6'd22 && pos_r < 6'd28) begin
          mac_nxt = {mac_r[arp_pkg::MAC_W-9:0], b};
        end
        if (pos_r >= 6'd28 && pos_r < 6'd32 && b != tgt_byte) ip_ok_nxt = 1'b0;
        if (in_ch.rx_last) begin
          if (armed_r && pos_r >= 6'd31 && eth_ok_nxt && op_ok_nxt && ip_ok_nxt) begin
            push              = 1'b1;
            push_entry.report = 1'b1;
            armed_nxt         = 1'b0;
          end
          pos_nxt    = '0;
          eth_ok_nxt = 1'b1;
          op_ok_nxt  = 1'b1;
          ip_ok_nxt  = 1'b1;
        end else if (pos_r != arp_pkg::POS_MAX) begin
          pos_nxt = pos_r + 1'b1;
        end
      end
    end
    push_entry.mac = mac_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      pos_r    <= '0;
      eth_ok_r <= 1'b1;
      op_ok_r  <= 1'b1;
      ip_ok_r  <= 1'b1;
      mac_r    <= '0;
    end else begin
      armed_r  <= armed_nxt;
      pos_r    <= pos_nxt;
      eth_ok_r <= eth_ok_nxt;
      op_ok_r  <= op_ok_nxt;
      ip_ok_r  <= ip_ok_nxt;
      mac_r    <= mac_nxt;
    end
  end

endmodule

// ===== src/arp_back.sv =====
// ----------------------------------------------------------------------------
// ARP back end
// Drains queued jobs: sends the request frame byte by byte or one report.
// ----------------------------------------------------------------------------
module arp_back #(
  parameter int REQUEST_LENGTH = 42
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arp_pkg::cfg_t       cfg,
  input  arp_pkg::q_entry_t   head,
  input  arp_pkg::q_status_t  q_status,
  output logic                pop,
  arp_out_if.source           out_ch
);

  localparam int CNT_W = $clog2(REQUEST_LENGTH);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(REQUEST_LENGTH - 1);

  arp_pkg::back_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         valid_r, valid_nxt;
  logic                         kind_r, kind_nxt;
  logic [7:0]                   byte_r, byte_nxt;
  logic                         last_r, last_nxt;
  logic [arp_pkg::MAC_W-1:0]    mac_r, mac_nxt;
  logic                         out_free;
  logic [7:0]                   req_byte;

  always_comb begin
    case (cnt_r)
      CNT_W'(0), CNT_W'(1), CNT_W'(2),
      CNT_W'(3), CNT_W'(4), CNT_W'(5):  req_byte = arp_pkg::BCAST_BYTE;
      CNT_W'(6),  CNT_W'(22):           req_byte = cfg.own_mac[47:40];
      CNT_W'(7),  CNT_W'(23):           req_byte = cfg.own_mac[39:32];
      CNT_W'(8),  CNT_W'(24):           req_byte = cfg.own_mac[31:24];
      CNT_W'(9),  CNT_W'(25):           req_byte = cfg.own_mac[23:16];
      CNT_W'(10), CNT_W'(26):           req_byte = cfg.own_mac[15:8];
      CNT_W'(11), CNT_W'(27):           req_byte = cfg.own_mac[7:0];
      CNT_W'(12):                       req_byte = arp_pkg::ETHERTYPE_ARP[15:8];
      CNT_W'(13):                       req_byte = arp_pkg::ETHERTYPE_ARP[7:0];
      CNT_W'(14):                       req_byte = arp_pkg::HTYPE_ETH[15:8];
      CNT_W'(15):                       req_byte = arp_pkg::HTYPE_ETH[7:0];
      CNT_W'(16):                       req_byte = arp_pkg::PTYPE_IPV4[15:8];
      CNT_W'(17):                       req_byte = arp_pkg::PTYPE_IPV4[7:0];
      CNT_W'(18):                       req_byte = arp_pkg::HLEN_ETH;
      CNT_W'(19):                       req_byte = arp_pkg::PLEN_IPV4;
      CNT_W'(20):                       req_byte = arp_pkg::OP_REQUEST[15:8];
      CNT_W'(21):                       req_byte = arp_pkg::OP_REQUEST[7:0];
      CNT_W'(28):                       req_byte = cfg.own_ip[31:24];
      CNT_W'(29):                       req_byte = cfg.own_ip[23:16];
      CNT_W'(30):                       req_byte = cfg.own_ip[15:8];
      CNT_W'(31):                       req_byte = cfg.own_ip[7:0];
      CNT_W'(38):                       req_byte = cfg.target_ip[31:24];
      CNT_W'(39):                       req_byte = cfg.target_ip[23:16];
      CNT_W'(40):                       req_byte = cfg.target_ip[15:8];
      CNT_W'(41):                       req_byte = cfg.target_ip[7:0];
      default:                          req_byte = 8'h00;
    endcase
  end

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    valid_nxt = valid_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    mac_nxt   = mac_r;
    pop       = 1'b0;
    if (out_free) begin
      case (state_r)
        arp_pkg::BK_SEND: begin
          valid_nxt = 1'b1;
          kind_nxt  = arp_pkg::KIND_TX;
          byte_nxt  = req_byte;
          last_nxt  = (cnt_r == LAST_POS);
          mac_nxt   = '0;
          if (cnt_r == LAST_POS) begin
            state_nxt = arp_pkg::BK_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        arp_pkg::BK_IDLE: begin
          valid_nxt = 1'b0;
          if (!q_status.empty) begin
            pop       = 1'b1;
            valid_nxt = 1'b1;
            if (head.report) begin
              kind_nxt = arp_pkg::KIND_REPORT;
              byte_nxt = 8'h00;
              last_nxt = 1'b0;
              mac_nxt  = head.mac;
            end else begin
              kind_nxt  = arp_pkg::KIND_TX;
              byte_nxt  = req_byte;
              last_nxt  = 1'b0;
              mac_nxt   = '0;
              state_nxt = arp_pkg::BK_SEND;
              cnt_nxt   = cnt_r + 1'b1;
            end
          end
        end
        default: begin
          state_nxt = arp_pkg::BK_IDLE;
          cnt_nxt   = '0;
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= arp_pkg::BK_IDLE;
      cnt_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    mac_r  <= mac_nxt;
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.tx_byte      = byte_r;
  assign out_ch.tx_last      = last_r;
  assign out_ch.resolved_mac = mac_r;

endmodule

// ===== src/arp_address_resolver_core.sv =====
// ----------------------------------------------------------------------------
// ARP address resolver core
// Sends broadcast ARP requests and reports the MAC of the matching reply.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : requests. command 0 starts a request frame and arms the block;
//            command 1 carries one received frame byte, rx_last on the last.
//   out_ch : results. kind 0 is one transmit byte (tx_last on the final one),
//            kind 1 reports resolved_mac of a matching ARP reply.
//   cfg_*  : write own_mac, own_ip and target_ip while the block is idle.
// Received bytes are taken at one per cycle while the job queue is not
// full. A start yields REQUEST_LENGTH output bytes, one per cycle while
// the receiver is ready, paced by the back end byte counter; the front
// end keeps parsing meanwhile until the four-entry job queue fills. A
// request's first result passes the job queue, then the output register.
// A stalled receiver holds the output register; jobs back up in the queue
// and in_ch.ready drops only when the queue is full.
// Reset clears the configuration, disarms and drops pending jobs; the block
// accepts requests in the first cycle after reset.
// ----------------------------------------------------------------------------
module arp_address_resolver_core #(
  parameter int REQUEST_LENGTH = 42
) (
  input  logic                              clk,
  input  logic                              rst_n,
  arp_in_if.sink                            in_ch,
  arp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [arp_pkg::MAC_W-1:0]         cfg_data
);

  arp_pkg::cfg_t       cfg_r, cfg_nxt;
  arp_pkg::q_entry_t   push_entry;
  arp_pkg::q_entry_t   head;
  arp_pkg::q_status_t  q_status;
  logic                push;
  logic                pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        arp_pkg::CFG_OWN_MAC:   cfg_nxt.own_mac   = cfg_data;
        arp_pkg::CFG_OWN_IP:    cfg_nxt.own_ip    = cfg_data[arp_pkg::IP_W-1:0];
        arp_pkg::CFG_TARGET_IP: cfg_nxt.target_ip = cfg_data[arp_pkg::IP_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  arp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .target_ip  (cfg_r.target_ip),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  arp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  arp_back #(
    .REQUEST_LENGTH (REQUEST_LENGTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/arp_checker.sv =====
// ----------------------------------------------------------------------------
// ARP resolver port checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`include "arp_address_resolver_core_macros.svh"

module arp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_tx_byte,
  input logic        out_tx_last,
  input logic [47:0] out_resolved_mac
);

  `ARP_ASSERT_ALWAYS(a_idle_after_reset, clk, !rst_n |=> !out_valid)

  `ARP_ASSERT(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable({out_kind, out_tx_byte, out_tx_last, out_resolved_mac}))

  `ARP_ASSERT(a_report_clean, clk, rst_n, out_valid && out_kind == arp_pkg::KIND_REPORT |-> !out_tx_last && out_tx_byte == 8'h00)

  `ARP_ASSERT(a_tx_no_mac, clk, rst_n, out_valid && out_kind == arp_pkg::KIND_TX |-> out_resolved_mac == '0)

endmodule

bind arp_address_resolver_core arp_checker u_arp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_tx_byte      (out_ch.tx_byte),
  .out_tx_last      (out_ch.tx_last),
  .out_resolved_mac (out_ch.resolved_mac)
);
